>>> sv/pfr_pkg.sv
// Shared types and constants for the page framebuffer refresh unit.
// No dependencies; used by the channel interfaces and the top level.
package pfr_pkg;

  // Default panel geometry.
  localparam int unsigned PanelWidthDefault = 128;
  localparam int unsigned PanelPagesDefault = 16;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_SEND  = 2'd2;

  // Panel command bytes sent ahead of each page.
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Input word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       is_data;
    logic       select_active;
    logic       busy_res;
    logic       frame_end;
  } out_word_t;

endpackage

>>> sv/pfr_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on pfr_pkg for the payload types.
interface pfr_in_if;
  logic              valid;
  logic              ready;
  pfr_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pfr_out_if;
  logic               valid;
  logic               ready;
  pfr_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/pfr_store.sv
// Frame store: single-port-write, registered-read memory with a clearing
// pass after reset. Depends on nothing but its parameters.
module pfr_store #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  output logic             clr_done_o
);

  logic [7:0]       mem [Depth];
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_done_q, clr_done_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  // Clearing pass walks every entry once after reset.
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_done_q <= clr_done_d;
    end
  end

  // The clearing pass owns the write port until it finishes.
  always_comb begin
    if (!clr_done_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = wr_en_i;
      mem_waddr = wr_addr_i;
      mem_wdata = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read, held between read enables.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign clr_done_o = clr_done_q;

endmodule

>>> sv/page_framebuffer_refresh_unit.sv
// Top level of the page framebuffer refresh unit.
// Depends on pfr_pkg, pfr_in_if, pfr_out_if and pfr_store.

// Each accepted word yields exactly one result word. In the accept cycle the
// frame store is read (the pixel's byte, or the next data byte of the
// refresh); in the execute state, once the output register is free, the
// byte is modified and written back or emitted, and the result goes into
// the output register. A stalled output holds the unit in its execute
// state; no word is accepted until the result is registered. After reset the
// frame store is cleared one byte per cycle, all its PANEL_WIDTH * PANEL_PAGES
// bytes (2048 by default), and no word is accepted until that pass is done.
// A refresh starts with a start word; each send word then yields one byte:
// per page the commands 0xB0+page, 0x00, 0x10, then PANEL_WIDTH data bytes.
module page_framebuffer_refresh_unit #(
  parameter int unsigned PANEL_WIDTH = pfr_pkg::PanelWidthDefault,
  parameter int unsigned PANEL_PAGES = pfr_pkg::PanelPagesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfr_in_if.sink    in_i,
  pfr_out_if.source out_o
);

  localparam int unsigned Depth = PANEL_WIDTH * PANEL_PAGES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ColW  = $clog2(PANEL_WIDTH);
  localparam int unsigned PageW = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CMD  = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [PageW-1:0]   page_q, page_d;
  logic [ColW-1:0]    col_q, col_d;
  pfr_pkg::in_word_t  item_q;
  logic [AddrW-1:0]   pix_addr_q;
  logic               pix_ok_q;
  logic               out_valid_q, out_valid_d;
  pfr_pkg::out_word_t out_word_q, out_word_d;

  logic               clr_done;
  logic               accept;
  logic               exec_fire;
  logic               pix_ok;
  logic [AddrW-1:0]   pix_addr;
  logic [AddrW-1:0]   send_addr;
  logic [AddrW-1:0]   rd_addr;
  logic [7:0]         rd_data;
  logic               wr_en;
  logic [7:0]         wr_data;
  logic [7:0]         pix_mask;

  // Frame store with its clearing pass.
  pfr_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (pix_addr_q),
    .wr_data_i  (wr_data),
    .clr_done_o (clr_done)
  );

  // Handshakes.
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);

  // Store address of the incoming pixel and of the next data byte.
  assign pix_ok = ({1'b0, in_i.payload.pixel_x} < 9'(PANEL_WIDTH)) &&
                  ({1'b0, in_i.payload.pixel_y} < 9'(8 * PANEL_PAGES));
  assign pix_addr = AddrW'(32'(in_i.payload.pixel_x) +
                           32'(in_i.payload.pixel_y[7:3]) * 32'(PANEL_WIDTH));
  assign send_addr = AddrW'(32'(page_q) * 32'(PANEL_WIDTH) + 32'(col_q));
  assign rd_addr   = (in_i.payload.kind == pfr_pkg::KIND_PIXEL) ? pix_addr : send_addr;

  // Read-modify-write of the pixel's byte.
  assign pix_mask = 8'h01 << item_q.pixel_y[2:0];
  assign wr_data  = item_q.pixel_on ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
  assign wr_en    = exec_fire && (item_q.kind == pfr_pkg::KIND_PIXEL) && pix_ok_q;

  // Control sequencing.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Refresh engine and result word.
  always_comb begin
    phase_d     = phase_q;
    page_d      = page_q;
    col_d       = col_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (exec_fire) begin
      out_word_d = '0;
      if (item_q.kind == pfr_pkg::KIND_START) begin
        if (phase_q == PH_IDLE) begin
          phase_d = PH_CMD;
          page_d  = '0;
          col_d   = '0;
        end
      end else if (item_q.kind == pfr_pkg::KIND_SEND && phase_q != PH_IDLE) begin
        out_word_d.byte_valid = 1'b1;
        if (phase_q == PH_CMD) begin
          // Command triple: page address, then column low and high.
          unique case (col_q[1:0])
            2'd0:    out_word_d.out_byte = pfr_pkg::CMD_PAGE_BASE + 8'(page_q);
            2'd1:    out_word_d.out_byte = pfr_pkg::CMD_COL_LOW;
            default: out_word_d.out_byte = pfr_pkg::CMD_COL_HIGH;
          endcase
          if (col_q >= ColW'(2)) begin
            phase_d = PH_DATA;
            col_d   = '0;
          end else begin
            col_d = col_q + ColW'(1);
          end
        end else begin
          // Data run of the current page.
          out_word_d.is_data  = 1'b1;
          out_word_d.out_byte = rd_data;
          if (col_q == ColW'(PANEL_WIDTH - 1)) begin
            col_d = '0;
            if (page_q == PageW'(PANEL_PAGES - 1)) begin
              out_word_d.frame_end = 1'b1;
              phase_d = PH_IDLE;
              page_d  = '0;
            end else begin
              page_d  = page_q + PageW'(1);
              phase_d = PH_CMD;
            end
          end else begin
            col_d = col_q + ColW'(1);
          end
        end
      end
      out_word_d.busy_res      = (phase_d != PH_IDLE);
      out_word_d.select_active = out_word_d.byte_valid || (phase_d != PH_IDLE);
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_IDLE;
      page_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      page_q      <= page_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_i.payload;
      pix_addr_q <= pix_addr;
      pix_ok_q   <= pix_ok;
    end
    out_word_q <= out_word_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

endmodule
